### src/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg: shared types, codes and the character lookup for the base64 decoder
// Holds the beat structures of both channels, the job passed from the front
// part to the back part, and the sextet lookup used by the front part.
// ----------------------------------------------------------------------------
package b64_pkg;

	// Input beat kinds.
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Result beat kinds.
	localparam logic OUT_DATA   = 1'b0;
	localparam logic OUT_STATUS = 1'b1;

	// Stream status codes.
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_INVALID    = 2'd1;
	localparam logic [1:0] ST_INCOMPLETE = 2'd2;

	// Sextet lookup results outside the six-bit range.
	localparam logic [6:0] SX_PAD = 7'd64;
	localparam logic [6:0] SX_BAD = 7'd65;

	// Characters of the alphabet and of the whitespace set.
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_9  = 8'h39;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// Sextet values that do not follow from a range offset.
	localparam logic [6:0] SX_LO_BASE  = 7'd26;
	localparam logic [6:0] SX_DIG_BASE = 7'd52;
	localparam logic [6:0] SX_PLUS     = 7'd62;
	localparam logic [6:0] SX_SLASH    = 7'd63;

	// Default depth of the job queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_in;
	} b64_in_beat_t;

	typedef struct packed {
		logic       out_kind;
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last;
	} b64_out_beat_t;

	// One job: either a decoded quad of one to three bytes or a stream status.
	typedef struct packed {
		logic            is_status;
		logic [1:0]      st;
		logic [1:0]      last_idx;
		logic [2:0][7:0] data;
	} b64_job_t;

	// Six-bit value of a character, SX_PAD for the pad character, SX_BAD otherwise.
	function automatic logic [6:0] sextet(input logic [7:0] c);
		logic [6:0] v;
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			v = 7'(c - CH_UP_A);
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			v = 7'(c - CH_LO_A) + SX_LO_BASE;
		end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
			v = 7'(c - CH_DIG_0) + SX_DIG_BASE;
		end else if (c == CH_PLUS) begin
			v = SX_PLUS;
		end else if (c == CH_SLASH) begin
			v = SX_SLASH;
		end else if (c == CH_EQUALS) begin
			v = SX_PAD;
		end else begin
			v = SX_BAD;
		end
		return v;
	endfunction

	// Space, or any of tab, line feed, vertical tab, form feed, carriage return.
	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

### src/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 decoder with end-of-stream status
//
//   channel | direction | payload          | handshake
//   char    | in        | b64_in_beat_t    | char_valid / char_ready
//   res     | out       | b64_out_beat_t   | res_valid / res_ready
//
// One character beat is accepted per cycle while the job queue has room.
// A completed quad or an end of stream becomes one job; the back part sends
// one beat per cycle while res_ready is high, and a quad gives 1 to 3 bytes.
// A job is registered in the queue and then in the back part before output.
// Reset clears the quad count, padding and error state and empties the queue.
// A stalled result side fills the queue after QUEUE_DEPTH plus one jobs.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
	parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_ready,
	input  b64_pkg::b64_in_beat_t  char_beat,
	output logic                   res_valid,
	input  logic                   res_ready,
	output b64_pkg::b64_out_beat_t res_beat
);

	logic              push;
	logic              pop;
	logic              full;
	logic              empty;
	b64_pkg::b64_job_t job_in;
	b64_pkg::b64_job_t job_out;

	// Front part: classification and quad assembly.
	b64_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_beat  (char_beat),
		.push       (push),
		.job        (job_in),
		.full       (full)
	);

	// Job queue.
	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.full    (full),
		.pop     (pop),
		.job_out (job_out),
		.empty   (empty)
	);

	// Back part: result beats.
	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.job       (job_out),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_beat  (res_beat)
	);

endmodule

### src/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue: short job queue between the front and back parts
// A small register FIFO; the head entry is visible combinationally.
// ----------------------------------------------------------------------------
module b64_queue #(
	parameter int DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b64_pkg::b64_job_t  job_in,
	output logic               full,
	input  logic               pop,
	output b64_pkg::b64_job_t  job_out,
	output logic               empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64_pkg::b64_job_t entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	// Push is refused when full; pop is refused when empty.
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign job_out = entries_q[rd_ptr_q];

	// Pointer and occupancy bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= job_in;
		end
	end

endmodule

### src/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front: character classification and quad assembly
// Takes one character beat per cycle while not full, tracks the quad, padding
// and error state, and pushes a job per valid quad and per end of stream.
// ----------------------------------------------------------------------------
module b64_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_ready,
	input  b64_pkg::b64_in_beat_t char_beat,
	output logic                  push,
	output b64_pkg::b64_job_t     job,
	input  logic                  full
);

	logic [6:0] quad_q [3];
	logic [1:0] count_q;
	logic       pad_seen_q;
	logic [1:0] err_q;

	logic [1:0] count_n;
	logic       pad_seen_n;
	logic [1:0] err_n;
	logic       wr_quad;
	logic       accept;
	logic [6:0] sx;
	logic       sx_pad;
	logic       sx_bad;
	logic [5:0] sa;
	logic [5:0] sb;
	logic [5:0] sc;

	assign char_ready = !full;
	assign accept     = char_valid && char_ready;
	assign sx         = b64_pkg::sextet(char_beat.char_in);
	assign sx_pad     = (sx == b64_pkg::SX_PAD);
	assign sx_bad     = (sx == b64_pkg::SX_BAD);
	assign sa         = quad_q[0][5:0];
	assign sb         = quad_q[1][5:0];
	assign sc         = quad_q[2][5:0];

	// Next state and job generation for the accepted beat.
	always_comb begin
		count_n    = count_q;
		pad_seen_n = pad_seen_q;
		err_n      = err_q;
		wr_quad    = 1'b0;
		push       = 1'b0;
		job        = '0;
		job.data[0] = {sa, sb[5:4]};
		job.data[1] = {sb[3:0], sc[5:2]};
		job.data[2] = {sc[1:0], sx[5:0]};
		if (accept) begin
			if (char_beat.kind == b64_pkg::KIND_END) begin
				job.is_status = 1'b1;
				job.data      = '0;
				if (err_q != b64_pkg::ST_OK) begin
					job.st = err_q;
				end else if (count_q != 2'd0) begin
					job.st = b64_pkg::ST_INCOMPLETE;
				end else begin
					job.st = b64_pkg::ST_OK;
				end
				push       = 1'b1;
				count_n    = '0;
				pad_seen_n = 1'b0;
				err_n      = b64_pkg::ST_OK;
			end else if (!b64_pkg::is_space(char_beat.char_in) &&
			             err_q == b64_pkg::ST_OK) begin
				if (pad_seen_q) begin
					err_n = b64_pkg::ST_INCOMPLETE;
				end else if (sx_bad || (sx_pad && count_q < 2'd2)) begin
					err_n = b64_pkg::ST_INVALID;
				end else if (count_q != 2'd3) begin
					wr_quad = 1'b1;
					count_n = count_q + 1'b1;
				end else begin
					// Fourth character completes the quad.
					count_n = '0;
					if (quad_q[2] == b64_pkg::SX_PAD) begin
						if (!sx_pad) begin
							err_n = b64_pkg::ST_INVALID;
						end else begin
							job.last_idx = 2'd0;
							pad_seen_n   = 1'b1;
							push         = 1'b1;
						end
					end else if (sx_pad) begin
						job.last_idx = 2'd1;
						pad_seen_n   = 1'b1;
						push         = 1'b1;
					end else begin
						job.last_idx = 2'd2;
						push         = 1'b1;
					end
				end
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			pad_seen_q <= 1'b0;
			err_q      <= b64_pkg::ST_OK;
		end else begin
			count_q    <= count_n;
			pad_seen_q <= pad_seen_n;
			err_q      <= err_n;
		end
	end

	// Quad character store, held as sextet codes.
	always_ff @(posedge clk) begin
		if (wr_quad) begin
			quad_q[count_q] <= sx;
		end
	end

endmodule

### src/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back: result sequencer
// Takes jobs from the queue and presents their beats from an output register,
// one per cycle while res_ready holds, marking each job's final beat as last.
// ----------------------------------------------------------------------------
module b64_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   empty,
	input  b64_pkg::b64_job_t      job,
	output logic                   pop,
	output logic                   res_valid,
	input  logic                   res_ready,
	output b64_pkg::b64_out_beat_t res_beat
);

	b64_pkg::b64_job_t cur_q;
	logic [1:0]        idx_q;
	logic              valid_q;
	logic              at_last;
	logic              load;

	assign at_last   = (idx_q == cur_q.last_idx);
	assign load      = !valid_q || (res_ready && at_last);
	assign pop       = load && !empty;
	assign res_valid = valid_q;

	// Beat formatting from the current job.
	always_comb begin
		res_beat.last = at_last;
		if (cur_q.is_status) begin
			res_beat.out_kind = b64_pkg::OUT_STATUS;
			res_beat.out_byte = '0;
			res_beat.status   = cur_q.st;
		end else begin
			res_beat.out_kind = b64_pkg::OUT_DATA;
			res_beat.out_byte = cur_q.data[idx_q];
			res_beat.status   = b64_pkg::ST_OK;
		end
	end

	// Valid and beat index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !empty;
			idx_q   <= '0;
		end else if (res_ready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Current job register.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= job;
		end
	end

endmodule

### src/b64_checker.sv
// ----------------------------------------------------------------------------
// b64_checker: port-level checks for the base64 decoder
// Watches the result channel for handshake and formatting faults.
// ----------------------------------------------------------------------------
module b64_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input b64_pkg::b64_out_beat_t res_beat
);

	// A stalled result beat stays valid.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// A stalled result beat keeps its payload.
	a_beat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_beat))
		else $error("result payload changed while stalled");

	// A status beat is always the last of its item and carries no byte.
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_beat.out_kind == b64_pkg::OUT_STATUS
		|-> res_beat.last && res_beat.out_byte == 8'd0)
		else $error("malformed status beat");

	// A data beat reports an ok status.
	a_data_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_beat.out_kind == b64_pkg::OUT_DATA
		|-> res_beat.status == b64_pkg::ST_OK)
		else $error("data beat with nonzero status");

	// Only defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_beat.status == b64_pkg::ST_OK ||
		res_beat.status == b64_pkg::ST_INVALID ||
		res_beat.status == b64_pkg::ST_INCOMPLETE)
		else $error("undefined status code");

endmodule

bind base64_stream_decoder b64_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_beat  (res_beat)
);
